// ===== sv/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Types, codes and thresholds shared by the flight phase classifier.
// ----------------------------------------------------------------------------
package fpc_pkg;

  typedef enum logic [3:0] {
    PH_UNKNOWN   = 4'd0,
    PH_PREFLIGHT = 4'd1,
    PH_TAXI      = 4'd2,
    PH_TAKEOFF   = 4'd3,
    PH_CLIMB     = 4'd4,
    PH_CRUISE    = 4'd5,
    PH_DESCENT   = 4'd6,
    PH_APPROACH  = 4'd7,
    PH_LANDING   = 4'd8,
    PH_GOAROUND  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    CAP_NONE = 3'd0,
    CAP_OUT  = 3'd1,
    CAP_OFF  = 3'd2,
    CAP_ON   = 3'd3,
    CAP_IN   = 3'd4
  } capture_t;

  // configuration register indexes
  localparam logic [0:0] CFG_CHECK_INTERVAL = 1'd0;
  localparam logic [0:0] CFG_CRUISE_ALT     = 1'd1;

  localparam logic [15:0] CHECK_INTERVAL_RST = 16'd100;
  localparam logic [15:0] CRUISE_ALT_RST     = 16'd0;

  // decision tree thresholds
  localparam logic [9:0]         TAXI_GS_MAX       = 10'd90;
  localparam logic [9:0]         ROLLOUT_GS_LIMIT  = 10'd30;
  localparam logic [10:0]        TAXI_N1_MAX       = 11'd850;
  localparam logic [6:0]         LANDING_FLAPS_MIN = 7'd99;
  localparam logic [15:0]        LOW_RALT_LIMIT    = 16'd500;
  localparam logic signed [15:0] VS_APPROACH       = -16'sd100;
  localparam logic signed [15:0] VS_DESCENT        = -16'sd400;
  localparam logic signed [15:0] VS_CLIMB          = 16'sd400;
  localparam logic signed [17:0] CRUISE_BAND       = 18'sd250;

  typedef struct packed {
    logic               sample_active;
    logic               on_ground;
    logic               any_engine_on;
    logic [9:0]         gnd_speed_kt;
    logic [10:0]        max_n1_tenths;
    logic [6:0]         flaps_percent;
    logic               approach_phase;
    logic [15:0]        radar_alt_ft;
    logic signed [15:0] vertical_speed_fpm;
    logic signed [16:0] baro_alt_ft;
    logic               gear_up;
    logic [15:0]        ms_since_prev;
  } sample_t;

  typedef struct packed {
    phase_t   phase;
    phase_t   phase_before;
    logic     phase_changed;
    capture_t capture_event;
  } result_t;

endpackage

// ===== sv/fpc_ifs.sv =====
// ----------------------------------------------------------------------------
// fpc channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fpc_sample_if;
  logic               valid;
  logic               ready;
  logic               sample_active;
  logic               on_ground;
  logic               any_engine_on;
  logic [9:0]         gnd_speed_kt;
  logic [10:0]        max_n1_tenths;
  logic [6:0]         flaps_percent;
  logic               approach_phase;
  logic [15:0]        radar_alt_ft;
  logic signed [15:0] vertical_speed_fpm;
  logic signed [16:0] baro_alt_ft;
  logic               gear_up;
  logic [15:0]        ms_since_prev;

  modport source (
    output valid, sample_active, on_ground, any_engine_on, gnd_speed_kt,
           max_n1_tenths, flaps_percent, approach_phase, radar_alt_ft,
           vertical_speed_fpm, baro_alt_ft, gear_up, ms_since_prev,
    input  ready
  );
  modport sink (
    input  valid, sample_active, on_ground, any_engine_on, gnd_speed_kt,
           max_n1_tenths, flaps_percent, approach_phase, radar_alt_ft,
           vertical_speed_fpm, baro_alt_ft, gear_up, ms_since_prev,
    output ready
  );
endinterface

interface fpc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic [3:0] phase_before;
  logic       phase_changed;
  logic [2:0] capture_event;

  modport source (
    output valid, phase, phase_before, phase_changed, capture_event,
    input  ready
  );
  modport sink (
    input  valid, phase, phase_before, phase_changed, capture_event,
    output ready
  );
endinterface

interface fpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/fpc_classify.sv =====
// ----------------------------------------------------------------------------
// fpc_classify
// Ground and air decision tree giving the next flight phase of one sample.
// ----------------------------------------------------------------------------
module fpc_classify (
  input  fpc_pkg::sample_t smp,
  input  fpc_pkg::phase_t  prev,
  input  logic [15:0]      cruise_alt_ft,
  output fpc_pkg::phase_t  next
);

  logic signed [17:0] alt_diff;
  logic               in_cruise_band;
  logic               low_ralt;
  fpc_pkg::phase_t    air_next;

  assign alt_diff       = 18'(smp.baro_alt_ft) - $signed({2'b00, cruise_alt_ft});
  assign in_cruise_band = (alt_diff < fpc_pkg::CRUISE_BAND) &&
                          (alt_diff > -fpc_pkg::CRUISE_BAND);
  assign low_ralt       = smp.radar_alt_ft < fpc_pkg::LOW_RALT_LIMIT;

  always_comb begin
    air_next = prev;
    priority if (smp.approach_phase) begin
      air_next = fpc_pkg::PH_APPROACH;
    end else if (low_ralt) begin
      if (prev == fpc_pkg::PH_DESCENT || smp.vertical_speed_fpm < fpc_pkg::VS_APPROACH) begin
        air_next = fpc_pkg::PH_APPROACH;
      end else if (prev != fpc_pkg::PH_APPROACH) begin
        air_next = fpc_pkg::PH_CLIMB;
      end
    end else if (in_cruise_band) begin
      air_next = fpc_pkg::PH_CRUISE;
    end else if ((!smp.gear_up || smp.flaps_percent != 7'd0) &&
                 prev == fpc_pkg::PH_DESCENT) begin
      air_next = fpc_pkg::PH_APPROACH;
    end else if (smp.vertical_speed_fpm < fpc_pkg::VS_DESCENT) begin
      if (prev != fpc_pkg::PH_APPROACH) begin
        air_next = fpc_pkg::PH_DESCENT;
      end
    end else if (smp.vertical_speed_fpm > fpc_pkg::VS_CLIMB) begin
      air_next = fpc_pkg::PH_CLIMB;
    end else if (prev == fpc_pkg::PH_TAKEOFF || prev == fpc_pkg::PH_LANDING) begin
      air_next = fpc_pkg::PH_CLIMB;
    end else if (prev == fpc_pkg::PH_CRUISE) begin
      air_next = fpc_pkg::PH_DESCENT;
    end else begin
      air_next = prev;
    end
    // airborne with nothing known yet is taken as climb
    if (air_next == fpc_pkg::PH_UNKNOWN) begin
      air_next = fpc_pkg::PH_CLIMB;
    end
  end

  always_comb begin
    next = prev;
    if (smp.on_ground) begin
      priority if (!smp.any_engine_on) begin
        next = fpc_pkg::PH_PREFLIGHT;
      end else if (prev == fpc_pkg::PH_LANDING) begin
        if (smp.gnd_speed_kt < fpc_pkg::ROLLOUT_GS_LIMIT) begin
          next = fpc_pkg::PH_TAXI;
        end
      end else if (smp.gnd_speed_kt <= fpc_pkg::TAXI_GS_MAX &&
                   smp.max_n1_tenths <= fpc_pkg::TAXI_N1_MAX) begin
        next = fpc_pkg::PH_TAXI;
      end else if (prev == fpc_pkg::PH_APPROACH ||
                   smp.flaps_percent > fpc_pkg::LANDING_FLAPS_MIN) begin
        next = fpc_pkg::PH_LANDING;
      end else begin
        next = fpc_pkg::PH_TAKEOFF;
      end
    end else begin
      next = air_next;
    end
  end

endmodule

// ===== sv/fpc_state.sv =====
// ----------------------------------------------------------------------------
// fpc_state
// Phase, previous phase and check timer, updated once per sample transfer.
// ----------------------------------------------------------------------------
module fpc_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  fpc_pkg::sample_t smp,
  input  logic [15:0]      check_interval_ms,
  input  logic [15:0]      cruise_alt_ft,
  output fpc_pkg::result_t res
);

  fpc_pkg::phase_t phase_r, phase_nxt;
  fpc_pkg::phase_t phase_before_r, phase_before_nxt;
  logic [15:0]     elapsed_r, elapsed_nxt;

  logic [16:0]     acc_sum;
  logic [15:0]     acc_sat;
  logic            evaluate;
  logic            changed;
  fpc_pkg::phase_t cls_next;
  fpc_pkg::capture_t capture;

  fpc_classify u_classify (
    .smp           (smp),
    .prev          (phase_r),
    .cruise_alt_ft (cruise_alt_ft),
    .next          (cls_next)
  );

  // saturating millisecond accumulator
  assign acc_sum = {1'b0, elapsed_r} + {1'b0, smp.ms_since_prev};
  assign acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];

  assign evaluate = smp.sample_active &&
                    !(phase_r != fpc_pkg::PH_UNKNOWN && acc_sat < check_interval_ms);
  assign changed  = evaluate && (cls_next != phase_r);

  always_comb begin
    capture = fpc_pkg::CAP_NONE;
    if (changed) begin
      priority if (cls_next == fpc_pkg::PH_TAXI && phase_r == fpc_pkg::PH_PREFLIGHT) begin
        capture = fpc_pkg::CAP_OUT;
      end else if (cls_next == fpc_pkg::PH_TAKEOFF) begin
        capture = fpc_pkg::CAP_OFF;
      end else if (cls_next == fpc_pkg::PH_LANDING) begin
        capture = fpc_pkg::CAP_ON;
      end else if (cls_next == fpc_pkg::PH_PREFLIGHT && phase_r == fpc_pkg::PH_TAXI) begin
        capture = fpc_pkg::CAP_IN;
      end else begin
        capture = fpc_pkg::CAP_NONE;
      end
    end
  end

  assign phase_nxt        = changed ? cls_next : phase_r;
  assign phase_before_nxt = changed ? phase_r : phase_before_r;
  assign elapsed_nxt      = evaluate ? 16'd0 : acc_sat;

  assign res.phase         = phase_nxt;
  assign res.phase_before  = phase_before_nxt;
  assign res.phase_changed = changed;
  assign res.capture_event = capture;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= fpc_pkg::PH_UNKNOWN;
      phase_before_r <= fpc_pkg::PH_UNKNOWN;
      elapsed_r      <= 16'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      phase_before_r <= phase_before_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

endmodule

// ===== sv/flight_phase_classifier.sv =====
// ----------------------------------------------------------------------------
// flight_phase_classifier
// Aircraft status samples in, flight phase and OOOI capture codes out.
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns exactly one result per sample; each
// sample passes through the input register and then the result register.
// The phase register closes a loop through the decision tree, so
// back-to-back samples are processed at full rate; a stall on the result
// side stops input only once both registers are full.
// Configuration writes are always accepted and must only be made while the
// block holds no sample in flight.
module flight_phase_classifier (
  input  logic      clk,
  input  logic      rst_n,
  fpc_sample_if.sink   in_ch,
  fpc_result_if.source out_ch,
  fpc_cfg_if.sink      cfg_ch
);

  logic [15:0]      check_interval_r;
  logic [15:0]      cruise_alt_r;

  logic             s1_valid_r;
  fpc_pkg::sample_t s1_r;
  logic             out_valid_r;
  fpc_pkg::result_t out_r;

  logic             s1_advance;
  logic             in_take;
  fpc_pkg::result_t res;
  fpc_pkg::sample_t in_smp;

  assign in_smp.sample_active      = in_ch.sample_active;
  assign in_smp.on_ground          = in_ch.on_ground;
  assign in_smp.any_engine_on      = in_ch.any_engine_on;
  assign in_smp.gnd_speed_kt       = in_ch.gnd_speed_kt;
  assign in_smp.max_n1_tenths      = in_ch.max_n1_tenths;
  assign in_smp.flaps_percent      = in_ch.flaps_percent;
  assign in_smp.approach_phase     = in_ch.approach_phase;
  assign in_smp.radar_alt_ft       = in_ch.radar_alt_ft;
  assign in_smp.vertical_speed_fpm = in_ch.vertical_speed_fpm;
  assign in_smp.baro_alt_ft        = in_ch.baro_alt_ft;
  assign in_smp.gear_up            = in_ch.gear_up;
  assign in_smp.ms_since_prev      = in_ch.ms_since_prev;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_interval_r <= fpc_pkg::CHECK_INTERVAL_RST;
      cruise_alt_r     <= fpc_pkg::CRUISE_ALT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        fpc_pkg::CFG_CHECK_INTERVAL: check_interval_r <= cfg_ch.wdata;
        fpc_pkg::CFG_CRUISE_ALT:     cruise_alt_r     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // two-register pipeline, the state update happens as a sample leaves s1
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  fpc_state u_state (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (s1_advance),
    .smp               (s1_r),
    .check_interval_ms (check_interval_r),
    .cruise_alt_ft     (cruise_alt_r),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_smp;
    end
    if (s1_advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phase         = out_r.phase;
  assign out_ch.phase_before  = out_r.phase_before;
  assign out_ch.phase_changed = out_r.phase_changed;
  assign out_ch.capture_event = out_r.capture_event;

`ifndef NO_ASSERTIONS
  a_change_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.phase_changed |-> out_r.phase != out_r.phase_before)
    else $error("phase change reported with equal phases");

  a_capture_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.capture_event != fpc_pkg::CAP_NONE |-> out_r.phase_changed)
    else $error("capture code without a phase change");

  a_change_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.phase_changed |-> out_r.phase != fpc_pkg::PH_UNKNOWN)
    else $error("phase changed to unknown");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled while pipeline has room");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flight phase classifier. A directed table walks
// the decision tree branch by branch, then randomised flight profiles run
// under several check intervals and cruise altitudes. Every result transfer is
// compared field by field with an in-bench predictor or pinned table result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    fpc_pkg::sample_t smp;
    logic             pinned;
    fpc_pkg::result_t want;
  } table_row_t;

  localparam fpc_pkg::result_t UNPINNED =
    '{fpc_pkg::PH_UNKNOWN, fpc_pkg::PH_UNKNOWN, 1'b0, fpc_pkg::CAP_NONE};

  // act, gnd, eng, gs, n1, flaps, appr, ralt, vs, baro, gear, ms
  localparam table_row_t DIRECTED [N_DIRECTED] = '{
    '{'{1'b0, 1'b1, 1'b1, 10'd1023, 11'd1270, 7'd100, 1'b1, 16'd65535, 16'sd32767,
        17'sd65535, 1'b1, 16'd0}, 1'b1,
      '{fpc_pkg::PH_UNKNOWN, fpc_pkg::PH_UNKNOWN, 1'b0, fpc_pkg::CAP_NONE}},
    '{'{1'b1, 1'b0, 1'b1, 10'd300, 11'd900, 7'd0, 1'b0, 16'd1000, 16'sd0,
        17'sd1000, 1'b1, 16'd0}, 1'b1,
      '{fpc_pkg::PH_CLIMB, fpc_pkg::PH_UNKNOWN, 1'b1, fpc_pkg::CAP_NONE}},
    '{'{1'b1, 1'b1, 1'b0, 10'd0, 11'd0, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd99}, 1'b1,
      '{fpc_pkg::PH_CLIMB, fpc_pkg::PH_UNKNOWN, 1'b0, fpc_pkg::CAP_NONE}},
    '{'{1'b1, 1'b1, 1'b0, 10'd0, 11'd0, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd1}, 1'b1,
      '{fpc_pkg::PH_PREFLIGHT, fpc_pkg::PH_CLIMB, 1'b1, fpc_pkg::CAP_NONE}},
    '{'{1'b1, 1'b1, 1'b1, 10'd0, 11'd0, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b1,
      '{fpc_pkg::PH_TAXI, fpc_pkg::PH_PREFLIGHT, 1'b1, fpc_pkg::CAP_OUT}},
    '{'{1'b1, 1'b1, 1'b1, 10'd90, 11'd850, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b1, 1'b1, 10'd91, 11'd850, 7'd99, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b1,
      '{fpc_pkg::PH_TAKEOFF, fpc_pkg::PH_TAXI, 1'b1, fpc_pkg::CAP_OFF}},
    '{'{1'b1, 1'b0, 1'b1, 10'd200, 11'd900, 7'd0, 1'b0, 16'd499, -16'sd100,
        17'sd0, 1'b0, 16'd65535}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b0, 16'd500, 16'sd0,
        17'sd249, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b0, 16'd500, 16'sd400,
        17'sd250, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd250, 11'd800, 7'd1, 1'b0, 16'd500, -16'sd401,
        -17'sd2048, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b0, 16'd65535, 16'sh8000,
        17'sd5000, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd150, 11'd600, 7'd30, 1'b0, 16'd0, 16'sd32767,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b1, 1'b1, 10'd1023, 11'd0, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b1,
      '{fpc_pkg::PH_LANDING, fpc_pkg::PH_APPROACH, 1'b1, fpc_pkg::CAP_ON}},
    '{'{1'b1, 1'b1, 1'b1, 10'd30, 11'd1270, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b1, 1'b1, 10'd29, 11'd1270, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b1, 1'b0, 10'd0, 11'd0, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b1,
      '{fpc_pkg::PH_PREFLIGHT, fpc_pkg::PH_TAXI, 1'b1, fpc_pkg::CAP_IN}},
    '{'{1'b1, 1'b1, 1'b1, 10'd5, 11'd100, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b1, 1'b1, 10'd100, 11'd300, 7'd100, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b0, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b1, 16'd65535, 16'sd0,
        17'sd0, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b0, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b1, 16'd65535}, 1'b0, UNPINNED},
    '{'{1'b0, 1'b0, 1'b1, 10'd250, 11'd800, 7'd0, 1'b0, 16'd0, 16'sd0,
        17'sd0, 1'b1, 16'd65535}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd300, 11'd900, 7'd0, 1'b0, 16'd10000, 16'sd1000,
        17'sd20000, 1'b1, 16'd0}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd300, 11'd700, 7'd0, 1'b0, 16'd600, -16'sd401,
        17'sd3000, 1'b1, 16'd100}, 1'b0, UNPINNED},
    '{'{1'b1, 1'b0, 1'b1, 10'd200, 11'd600, 7'd20, 1'b0, 16'd499, 16'sd0,
        17'sd2000, 1'b0, 16'd100}, 1'b0, UNPINNED}
  };

  logic clk = 1'b0;
  logic rst_n;

  fpc_sample_if in_if ();
  fpc_result_if out_if ();
  fpc_cfg_if    cfg_if ();

  flight_phase_classifier u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  // predictor state, mirrors the block after every accepted sample
  fpc_pkg::phase_t phase_now   = fpc_pkg::PH_UNKNOWN;
  fpc_pkg::phase_t phase_prior = fpc_pkg::PH_UNKNOWN;
  logic [15:0]     elapsed_ms  = 16'd0;
  logic [15:0]     interval_ms = 16'd100;
  logic [15:0]     cruise_ft   = 16'd0;

  fpc_pkg::result_t phase_reports_due [$];
  int               mismatches  = 0;
  int               cycle_count = 0;
  logic             steady_flow = 1'b0;

  function automatic fpc_pkg::phase_t classify_phase(fpc_pkg::sample_t s,
                                                     fpc_pkg::phase_t prev);
    fpc_pkg::phase_t nxt;
    int              gs, n1, flaps, ralt, vs, baro, band;
    nxt   = prev;
    gs    = int'(s.gnd_speed_kt);
    n1    = int'(s.max_n1_tenths);
    flaps = int'(s.flaps_percent);
    ralt  = int'(s.radar_alt_ft);
    vs    = int'($signed(s.vertical_speed_fpm));
    baro  = int'($signed(s.baro_alt_ft));
    if (s.on_ground) begin
      if (!s.any_engine_on) begin
        nxt = fpc_pkg::PH_PREFLIGHT;
      end else if (prev == fpc_pkg::PH_LANDING) begin
        if (gs < 30) nxt = fpc_pkg::PH_TAXI;
      end else if (gs <= 90 && n1 <= 850) begin
        nxt = fpc_pkg::PH_TAXI;
      end else if (prev == fpc_pkg::PH_APPROACH || flaps > 99) begin
        nxt = fpc_pkg::PH_LANDING;
      end else begin
        nxt = fpc_pkg::PH_TAKEOFF;
      end
      return nxt;
    end
    band = baro - int'(cruise_ft);
    if (band < 0) band = -band;
    if (s.approach_phase) begin
      nxt = fpc_pkg::PH_APPROACH;
    end else if (ralt < 500) begin
      if (prev == fpc_pkg::PH_DESCENT || vs < -100) nxt = fpc_pkg::PH_APPROACH;
      else if (prev != fpc_pkg::PH_APPROACH) nxt = fpc_pkg::PH_CLIMB;
    end else if (band < 250) begin
      nxt = fpc_pkg::PH_CRUISE;
    end else if ((!s.gear_up || flaps != 0) && prev == fpc_pkg::PH_DESCENT) begin
      nxt = fpc_pkg::PH_APPROACH;
    end else if (vs < -400) begin
      if (prev != fpc_pkg::PH_APPROACH) nxt = fpc_pkg::PH_DESCENT;
    end else if (vs > 400) begin
      nxt = fpc_pkg::PH_CLIMB;
    end else if (prev == fpc_pkg::PH_TAKEOFF || prev == fpc_pkg::PH_LANDING) begin
      nxt = fpc_pkg::PH_CLIMB;
    end else if (prev == fpc_pkg::PH_CRUISE) begin
      nxt = fpc_pkg::PH_DESCENT;
    end
    // a first airborne fix with nothing conclusive still counts as climb
    if (nxt == fpc_pkg::PH_UNKNOWN) nxt = fpc_pkg::PH_CLIMB;
    return nxt;
  endfunction

  function automatic fpc_pkg::result_t advance_phase(fpc_pkg::sample_t s);
    fpc_pkg::result_t r;
    fpc_pkg::phase_t  nxt;
    int               sum;
    sum = int'(elapsed_ms) + int'(s.ms_since_prev);
    elapsed_ms = (sum > 65535) ? 16'hFFFF : 16'(sum);
    r.phase_changed = 1'b0;
    r.capture_event = fpc_pkg::CAP_NONE;
    if (s.sample_active &&
        !(phase_now != fpc_pkg::PH_UNKNOWN && elapsed_ms < interval_ms)) begin
      elapsed_ms = 16'd0;
      nxt = classify_phase(s, phase_now);
      if (nxt != phase_now) begin
        r.phase_changed = 1'b1;
        if (nxt == fpc_pkg::PH_TAXI && phase_now == fpc_pkg::PH_PREFLIGHT)
          r.capture_event = fpc_pkg::CAP_OUT;
        else if (nxt == fpc_pkg::PH_TAKEOFF)
          r.capture_event = fpc_pkg::CAP_OFF;
        else if (nxt == fpc_pkg::PH_LANDING)
          r.capture_event = fpc_pkg::CAP_ON;
        else if (nxt == fpc_pkg::PH_PREFLIGHT && phase_now == fpc_pkg::PH_TAXI)
          r.capture_event = fpc_pkg::CAP_IN;
        phase_prior = phase_now;
        phase_now   = nxt;
      end
    end
    r.phase        = phase_now;
    r.phase_before = phase_prior;
    return r;
  endfunction

  // random sample shaped by the flight stage, one in five left as pure noise
  function automatic fpc_pkg::sample_t flight_sample(int stage);
    fpc_pkg::sample_t s;
    int               b, m;
    s.sample_active      = ($urandom_range(0, 9) != 0);
    s.on_ground          = 1'($urandom_range(0, 1));
    s.any_engine_on      = 1'($urandom_range(0, 1));
    s.gnd_speed_kt       = 10'($urandom_range(0, 1023));
    s.max_n1_tenths      = 11'($urandom_range(0, 1270));
    s.flaps_percent      = 7'($urandom_range(0, 100));
    s.approach_phase     = 1'($urandom_range(0, 1));
    s.radar_alt_ft       = 16'($urandom);
    s.vertical_speed_fpm = 16'($urandom);
    b                    = int'($urandom_range(0, 67583)) - 2048;
    s.gear_up            = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       m = 0;
      1:       m = 65535;
      default: m = int'($urandom_range(0, 2 * int'(interval_ms) + 2));
    endcase
    if (m > 65535) m = 65535;
    s.ms_since_prev = 16'(m);
    if ($urandom_range(0, 4) != 0) begin
      case (stage)
        0: begin
          s.on_ground     = 1'b1;
          s.any_engine_on = ($urandom_range(0, 2) == 0);
          s.gnd_speed_kt  = 10'($urandom_range(0, 5));
        end
        1: begin
          s.on_ground     = 1'b1;
          s.any_engine_on = 1'b1;
          s.gnd_speed_kt  = 10'($urandom_range(0, 95));
          s.max_n1_tenths = 11'($urandom_range(200, 900));
        end
        2: begin
          s.on_ground     = 1'b1;
          s.any_engine_on = 1'b1;
          s.gnd_speed_kt  = 10'($urandom_range(60, 200));
          s.max_n1_tenths = 11'($urandom_range(800, 1270));
        end
        3: begin
          s.on_ground          = 1'b0;
          s.approach_phase     = 1'b0;
          s.radar_alt_ft       = 16'($urandom_range(0, 3000));
          s.vertical_speed_fpm = 16'($urandom_range(300, 3000));
        end
        4: begin
          s.on_ground          = 1'b0;
          s.approach_phase     = 1'b0;
          s.radar_alt_ft       = 16'($urandom_range(500, 65535));
          b                    = int'(cruise_ft) + int'($urandom_range(0, 600)) - 300;
          s.vertical_speed_fpm = 16'(int'($urandom_range(0, 1000)) - 500);
        end
        5: begin
          s.on_ground          = 1'b0;
          s.approach_phase     = 1'b0;
          s.radar_alt_ft       = 16'($urandom_range(400, 30000));
          s.vertical_speed_fpm = 16'(-int'($urandom_range(300, 3000)));
          s.gear_up            = ($urandom_range(0, 3) != 0);
          if ($urandom_range(0, 2) != 0) s.flaps_percent = 7'd0;
        end
        6: begin
          s.on_ground          = 1'b0;
          s.approach_phase     = ($urandom_range(0, 2) == 0);
          s.radar_alt_ft       = 16'($urandom_range(0, 1000));
          s.vertical_speed_fpm = 16'(-int'($urandom_range(0, 1500)));
        end
        7: begin
          s.on_ground     = 1'b1;
          s.any_engine_on = 1'b1;
          s.gnd_speed_kt  = 10'($urandom_range(20, 160));
          s.max_n1_tenths = 11'($urandom_range(0, 1000));
          s.flaps_percent = 7'($urandom_range(90, 100));
        end
        default: begin
          s.on_ground     = 1'b1;
          s.any_engine_on = 1'b1;
          s.gnd_speed_kt  = 10'($urandom_range(0, 40));
          s.max_n1_tenths = 11'($urandom_range(0, 600));
        end
      endcase
    end
    if (b < -2048) b = -2048;
    if (b > 65535) b = 65535;
    s.baro_alt_ft = 17'(b);
    return s;
  endfunction

  // all tasks below are entered and left right after a rising edge
  task automatic idle_sender();
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 34) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_sample(input fpc_pkg::sample_t s, input logic pinned,
                             input fpc_pkg::result_t want);
    fpc_pkg::result_t predicted;
    in_if.valid              <= 1'b1;
    in_if.sample_active      <= s.sample_active;
    in_if.on_ground          <= s.on_ground;
    in_if.any_engine_on      <= s.any_engine_on;
    in_if.gnd_speed_kt       <= s.gnd_speed_kt;
    in_if.max_n1_tenths      <= s.max_n1_tenths;
    in_if.flaps_percent      <= s.flaps_percent;
    in_if.approach_phase     <= s.approach_phase;
    in_if.radar_alt_ft       <= s.radar_alt_ft;
    in_if.vertical_speed_fpm <= s.vertical_speed_fpm;
    in_if.baro_alt_ft        <= s.baro_alt_ft;
    in_if.gear_up            <= s.gear_up;
    in_if.ms_since_prev      <= s.ms_since_prev;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = advance_phase(s);
    phase_reports_due.push_back(pinned ? want : predicted);
  endtask

  task automatic wait_all_reported();
    in_if.valid <= 1'b0;
    while (phase_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      fpc_pkg::CFG_CHECK_INTERVAL: interval_ms = value;
      fpc_pkg::CFG_CRUISE_ALT:     cruise_ft   = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] interval, input logic [15:0] cruise);
    write_reg(fpc_pkg::CFG_CHECK_INTERVAL, interval);
    write_reg(fpc_pkg::CFG_CRUISE_ALT, cruise);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_flights(input int n_items);
    int stage;
    stage = 0;
    repeat (n_items) begin
      idle_sender();
      send_sample(flight_sample(stage), 1'b0, UNPINNED);
      if ($urandom_range(0, 5) == 0) stage = (stage + 1) % 9;
    end
    wait_all_reported();
  endtask

  always @(posedge clk) begin
    out_if.ready <= steady_flow || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    fpc_pkg::result_t due;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (phase_reports_due.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        due = phase_reports_due.pop_front();
        if (out_if.phase !== due.phase) begin
          $error("phase: expected %0d, actual %0d", due.phase, out_if.phase);
          mismatches++;
        end
        if (out_if.phase_before !== due.phase_before) begin
          $error("phase_before: expected %0d, actual %0d", due.phase_before,
                 out_if.phase_before);
          mismatches++;
        end
        if (out_if.phase_changed !== due.phase_changed) begin
          $error("phase_changed: expected %0d, actual %0d", due.phase_changed,
                 out_if.phase_changed);
          mismatches++;
        end
        if (out_if.capture_event !== due.capture_event) begin
          $error("capture_event: expected %0d, actual %0d", due.capture_event,
                 out_if.capture_event);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample_active      <= 1'b0;
    in_if.on_ground          <= 1'b0;
    in_if.any_engine_on      <= 1'b0;
    in_if.gnd_speed_kt       <= '0;
    in_if.max_n1_tenths      <= '0;
    in_if.flaps_percent      <= '0;
    in_if.approach_phase     <= 1'b0;
    in_if.radar_alt_ft       <= '0;
    in_if.vertical_speed_fpm <= '0;
    in_if.baro_alt_ft        <= '0;
    in_if.gear_up            <= 1'b0;
    in_if.ms_since_prev      <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= fpc_pkg::CFG_CHECK_INTERVAL;
    cfg_if.wdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk runs on the reset values of both registers
    for (r = 0; r < N_DIRECTED; r++) begin
      idle_sender();
      send_sample(DIRECTED[r].smp, DIRECTED[r].pinned, DIRECTED[r].want);
    end
    wait_all_reported();

    set_config(16'd0, 16'd0);
    run_flights(300);
    // once a phase is known, only an accumulator at its 65535 ms ceiling evaluates
    set_config(16'd65535, 16'd65535);
    run_flights(300);
    set_config(16'($urandom_range(1, 300)), 16'($urandom_range(1000, 45000)));
    steady_flow = 1'b1;
    run_flights(375);
    steady_flow = 1'b0;
    set_config(16'd100, 16'd35000);
    run_flights(375);
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    run_flights(150);
    set_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)));
    run_flights(200);

    // let any stray transfer show up before the verdict
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== flight_phase_classifier.f =====
sv/fpc_pkg.sv
sv/fpc_ifs.sv
sv/fpc_classify.sv
sv/fpc_state.sv
sv/flight_phase_classifier.sv
dv/tb_top.sv
